[hdl/cclt_pkg.sv]
// ----------------------------------------------------------------------------
// cclt_pkg
// Shared types, character codes and helpers of the content-line tokenizer.
// ----------------------------------------------------------------------------
package cclt_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

    typedef enum logic [3:0] {
        MODE_LINE     = 4'd0,
        MODE_LINE_CR  = 4'd1,
        MODE_SKIP     = 4'd2,
        MODE_NAME     = 4'd3,
        MODE_PNAME    = 4'd4,
        MODE_PV_START = 4'd5,
        MODE_PV       = 4'd6,
        MODE_PV_Q     = 4'd7,
        MODE_PQ_END   = 4'd8,
        MODE_VALUE    = 4'd9,
        MODE_VAL_CR   = 4'd10,
        MODE_VAL_NL   = 4'd11,
        MODE_FOLD     = 4'd12
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NAME_CHAR   = 3'd0,
        KIND_PNAME_CHAR  = 3'd1,
        KIND_PVALUE_CHAR = 3'd2,
        KIND_VALUE_CHAR  = 3'd3,
        KIND_PARAM_KEPT  = 3'd4,
        KIND_PROP_ENDED  = 3'd5,
        KIND_PROP_DROP   = 3'd6,
        KIND_PARAM_DISC  = 3'd7
    } kind_t;

    typedef struct packed {
        mode_t mode;
        logic  value_seen;
        logic  pname_seen;
        logic  pvalue_seen;
    } scan_state_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
    } result_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } out_item_t;

    typedef struct packed {
        scan_state_t nxt;
        logic [1:0]  count;
        result_t     r0;
        result_t     r1;
    } step_t;

    localparam scan_state_t SCAN_RESET = '{
        mode: MODE_LINE, value_seen: 1'b0, pname_seen: 1'b0, pvalue_seen: 1'b0
    };

    function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h61:8'h7A]}) ? c - CASE_GAP : c;
    endfunction

    function automatic logic is_eol(input logic [CHAR_W-1:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    // Mode after a dropped line: wait for the line end unless this is it.
    function automatic mode_t drop_mode(input logic [CHAR_W-1:0] c);
        if (c == CH_CR) begin
            return MODE_LINE_CR;
        end else if (c == CH_LF) begin
            return MODE_LINE;
        end else begin
            return MODE_SKIP;
        end
    endfunction

endpackage

[hdl/cclt_step.sv]
// ----------------------------------------------------------------------------
// cclt_step
// Next scan state and up to two result tokens for one text byte.
// ----------------------------------------------------------------------------
module cclt_step (
    input  cclt_pkg::scan_state_t          cur,
    input  logic [cclt_pkg::CHAR_W-1:0]    text_byte,
    input  logic                           end_of_text,
    output cclt_pkg::step_t                step
);
    import cclt_pkg::*;

    logic              eot;
    logic [CHAR_W-1:0] c;
    scan_state_t       nxt;
    logic [1:0]        cnt;
    result_t           r0;
    result_t           r1;
    kind_t             close_kind;
    kind_t             end_kind;

    assign c          = text_byte;
    assign eot        = end_of_text || (text_byte == CH_NUL);
    assign close_kind = cur.pvalue_seen ? KIND_PARAM_KEPT : KIND_PARAM_DISC;
    assign end_kind   = cur.value_seen ? KIND_PROP_ENDED : KIND_PROP_DROP;

    always_comb begin
        nxt = cur;
        cnt = 2'd0;
        r0  = '{kind: KIND_NAME_CHAR, ch: CH_NUL};
        r1  = '{kind: KIND_NAME_CHAR, ch: CH_NUL};
        if (eot) begin
            case (cur.mode)
                MODE_NAME, MODE_PNAME, MODE_PV_START, MODE_PV, MODE_PV_Q,
                MODE_PQ_END: begin
                    r0  = '{kind: KIND_PROP_DROP, ch: CH_NUL};
                    cnt = 2'd1;
                end
                MODE_VALUE, MODE_VAL_CR, MODE_VAL_NL, MODE_FOLD: begin
                    r0  = '{kind: end_kind, ch: CH_NUL};
                    cnt = 2'd1;
                end
                default: begin
                end
            endcase
            nxt = SCAN_RESET;
        end else begin
            case (cur.mode)
                MODE_SKIP: begin
                    if (c == CH_CR) begin
                        nxt.mode = MODE_LINE_CR;
                    end else if (c == CH_LF) begin
                        nxt.mode = MODE_LINE;
                    end
                end
                MODE_NAME: begin
                    if (c == CH_COLON) begin
                        nxt.mode       = MODE_VALUE;
                        nxt.value_seen = 1'b0;
                    end else if (c == CH_SEMI) begin
                        nxt.mode        = MODE_PNAME;
                        nxt.pname_seen  = 1'b0;
                        nxt.pvalue_seen = 1'b0;
                    end else if (is_eol(c)) begin
                        r0       = '{kind: KIND_PROP_DROP, ch: CH_NUL};
                        cnt      = 2'd1;
                        nxt.mode = drop_mode(c);
                    end else begin
                        r0  = '{kind: KIND_NAME_CHAR, ch: to_upper(c)};
                        cnt = 2'd1;
                    end
                end
                MODE_PNAME: begin
                    if (c == CH_EQ) begin
                        if (cur.pname_seen) begin
                            nxt.mode = MODE_PV_START;
                        end else begin
                            r0       = '{kind: KIND_PROP_DROP, ch: CH_NUL};
                            cnt      = 2'd1;
                            nxt.mode = drop_mode(c);
                        end
                    end else if (c == CH_COLON) begin
                        r0             = '{kind: close_kind, ch: CH_NUL};
                        cnt            = 2'd1;
                        nxt.mode       = MODE_VALUE;
                        nxt.value_seen = 1'b0;
                    end else if (is_eol(c)) begin
                        r0       = '{kind: KIND_PROP_DROP, ch: CH_NUL};
                        cnt      = 2'd1;
                        nxt.mode = drop_mode(c);
                    end else begin
                        r0             = '{kind: KIND_PNAME_CHAR, ch: to_upper(c)};
                        cnt            = 2'd1;
                        nxt.pname_seen = 1'b1;
                    end
                end
                MODE_PV_START, MODE_PV: begin
                    if ((cur.mode == MODE_PV_START) && (c == CH_QUOTE)) begin
                        nxt.mode = MODE_PV_Q;
                    end else if (c == CH_SEMI) begin
                        r0              = '{kind: close_kind, ch: CH_NUL};
                        cnt             = 2'd1;
                        nxt.mode        = MODE_PNAME;
                        nxt.pname_seen  = 1'b0;
                        nxt.pvalue_seen = 1'b0;
                    end else if (c == CH_COLON) begin
                        r0             = '{kind: close_kind, ch: CH_NUL};
                        cnt            = 2'd1;
                        nxt.mode       = MODE_VALUE;
                        nxt.value_seen = 1'b0;
                    end else if (is_eol(c)) begin
                        r0       = '{kind: KIND_PROP_DROP, ch: CH_NUL};
                        cnt      = 2'd1;
                        nxt.mode = drop_mode(c);
                    end else begin
                        r0              = '{kind: KIND_PVALUE_CHAR, ch: c};
                        cnt             = 2'd1;
                        nxt.pvalue_seen = 1'b1;
                        nxt.mode        = MODE_PV;
                    end
                end
                MODE_PV_Q: begin
                    if (c == CH_QUOTE) begin
                        r0       = '{kind: close_kind, ch: CH_NUL};
                        cnt      = 2'd1;
                        nxt.mode = MODE_PQ_END;
                    end else if (is_eol(c)) begin
                        r0       = '{kind: KIND_PROP_DROP, ch: CH_NUL};
                        cnt      = 2'd1;
                        nxt.mode = drop_mode(c);
                    end else begin
                        r0              = '{kind: KIND_PVALUE_CHAR, ch: c};
                        cnt             = 2'd1;
                        nxt.pvalue_seen = 1'b1;
                    end
                end
                MODE_PQ_END: begin
                    if (c == CH_SEMI) begin
                        nxt.mode        = MODE_PNAME;
                        nxt.pname_seen  = 1'b0;
                        nxt.pvalue_seen = 1'b0;
                    end else if (c == CH_COLON) begin
                        nxt.mode       = MODE_VALUE;
                        nxt.value_seen = 1'b0;
                    end else begin
                        r0       = '{kind: KIND_PROP_DROP, ch: CH_NUL};
                        cnt      = 2'd1;
                        nxt.mode = drop_mode(c);
                    end
                end
                MODE_VALUE, MODE_FOLD: begin
                    if ((cur.mode == MODE_FOLD) && is_blank(c)) begin
                        nxt.mode = MODE_FOLD;
                    end else if (c == CH_CR) begin
                        nxt.mode = MODE_VAL_CR;
                    end else if (c == CH_LF) begin
                        nxt.mode = MODE_VAL_NL;
                    end else begin
                        r0             = '{kind: KIND_VALUE_CHAR, ch: c};
                        cnt            = 2'd1;
                        nxt.value_seen = 1'b1;
                        nxt.mode       = MODE_VALUE;
                    end
                end
                MODE_VAL_CR, MODE_VAL_NL: begin
                    if ((cur.mode == MODE_VAL_CR) && (c == CH_LF)) begin
                        nxt.mode = MODE_VAL_NL;
                    end else if (is_blank(c)) begin
                        // folded line: one space, then skip leading blanks
                        r0             = '{kind: KIND_VALUE_CHAR, ch: CH_SP};
                        cnt            = 2'd1;
                        nxt.value_seen = 1'b1;
                        nxt.mode       = MODE_FOLD;
                    end else begin
                        r0  = '{kind: end_kind, ch: CH_NUL};
                        cnt = 2'd1;
                        if (c == CH_CR) begin
                            nxt.mode = MODE_LINE_CR;
                        end else if (c == CH_LF) begin
                            nxt.mode = MODE_LINE;
                        end else if ((c == CH_COLON) || (c == CH_SEMI)) begin
                            nxt.mode = MODE_SKIP;
                        end else begin
                            r1       = '{kind: KIND_NAME_CHAR, ch: to_upper(c)};
                            cnt      = 2'd2;
                            nxt.mode = MODE_NAME;
                        end
                    end
                end
                default: begin
                    // line start; also taken for unused mode codes
                    if ((cur.mode == MODE_LINE_CR) && (c == CH_LF)) begin
                        nxt.mode = MODE_LINE;
                    end else if (c == CH_CR) begin
                        nxt.mode = MODE_LINE_CR;
                    end else if (c == CH_LF) begin
                        nxt.mode = MODE_LINE;
                    end else if ((c == CH_COLON) || (c == CH_SEMI)) begin
                        nxt.mode = MODE_SKIP;
                    end else begin
                        r0       = '{kind: KIND_NAME_CHAR, ch: to_upper(c)};
                        cnt      = 2'd1;
                        nxt.mode = MODE_NAME;
                    end
                end
            endcase
        end
    end

    assign step = '{nxt: nxt, count: cnt, r0: r0, r1: r1};

endmodule

[hdl/cclt_outq.sv]
// ----------------------------------------------------------------------------
// cclt_outq
// Small result queue: takes up to two items per cycle, hands out one.
// ----------------------------------------------------------------------------
module cclt_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            push_count,
    input  cclt_pkg::out_item_t   push_item0,
    input  cclt_pkg::out_item_t   push_item1,
    output logic                  room_for_two,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cclt_pkg::out_item_t   out_item
);
    import cclt_pkg::*;

    out_item_t               entry_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0]   wr_ptr_next;
    logic [OUTQ_PTR_W-1:0]   rd_ptr_reg;
    logic [OUTQ_PTR_W-1:0]   rd_ptr_next;
    logic [OUTQ_CNT_W-1:0]   count_reg;
    logic [OUTQ_CNT_W-1:0]   count_next;
    logic [OUTQ_PTR_W-1:0]   wr_ptr_plus1;
    logic                    pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_item     = entry_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + OUTQ_PTR_W'(1);

    assign wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + OUTQ_PTR_W'(pop);
    assign count_next  = count_reg + OUTQ_CNT_W'(push_count) - OUTQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_item0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push_item1;
        end
    end

    // drop nothing: never push two items unless there is room for two
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count == 2'd2) |-> room_for_two)
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (count_reg ==
            $past(count_reg) + OUTQ_CNT_W'($past(push_count)) - OUTQ_CNT_W'($past(pop))))
        else $error("result queue count out of step");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (OUTQ_PTR_W'(wr_ptr_reg - rd_ptr_reg) == OUTQ_PTR_W'(count_reg)))
        else $error("result queue pointers disagree with count");

endmodule

[hdl/calendar_content_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// calendar_content_line_tokenizer
// Byte-wise tokenizer for calendar content lines (name, params, value).
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one text byte per item (s_text_byte), or an end-of-text mark
//   (s_end_of_text, or a zero byte) that closes any open property and returns
//   the scanner to line start.
//   m_ channel: result tokens (m_token_kind, m_out_char); m_last_result flags
//   the final token caused by one input item. An item gives zero, one or two
//   tokens; items that give none (line ends, skipped text) leave no trace.
// Output: tokens are registered in the result queue and offered on m_ in order.
// Throughput: one byte per cycle while s_ready is high; the combinational scan
//   step feeds a four-entry result queue. Bytes that produce two tokens (a line
//   that starts right after a property value) can build up the queue; s_ready
//   stays high while the queue has room for two tokens.
// Reset: aresetn (synchronous, active low) empties the queue and puts the
//   scanner at line start with all flags clear.
// Stall: when m_ready is low, tokens wait in the queue; s_ready drops once
//   fewer than two free entries remain, so nothing is ever lost.
// ----------------------------------------------------------------------------
module calendar_content_line_tokenizer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cclt_pkg::CHAR_W-1:0]    s_text_byte,
    input  logic                           s_end_of_text,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cclt_pkg::KIND_W-1:0]    m_token_kind,
    output logic [cclt_pkg::CHAR_W-1:0]    m_out_char,
    output logic                           m_last_result
);
    import cclt_pkg::*;

    scan_state_t scan_reg;
    scan_state_t scan_next;
    step_t       step;
    logic        s_fire;
    logic        room_for_two;
    logic [1:0]  push_count;
    out_item_t   push_item0;
    out_item_t   push_item1;
    out_item_t   head_item;

    // accept a byte whenever the queue can absorb the worst case of two tokens
    assign s_ready = room_for_two;
    assign s_fire  = s_valid && s_ready;

    cclt_step u_step (
        .cur         (scan_reg),
        .text_byte   (s_text_byte),
        .end_of_text (s_end_of_text),
        .step        (step)
    );

    // advance the scanner only on an accepted item; hold otherwise
    assign scan_next = s_fire ? step.nxt : scan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= SCAN_RESET;
        end else begin
            scan_reg <= scan_next;
        end
    end

    // tag the final token of this item as last
    assign push_count = s_fire ? step.count : 2'd0;
    assign push_item0 = '{kind: step.r0.kind, ch: step.r0.ch, last: (step.count == 2'd1)};
    assign push_item1 = '{kind: step.r1.kind, ch: step.r1.ch, last: 1'b1};

    cclt_outq u_outq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_count   (push_count),
        .push_item0   (push_item0),
        .push_item1   (push_item1),
        .room_for_two (room_for_two),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_item     (head_item)
    );

    assign m_token_kind  = KIND_W'(head_item.kind);
    assign m_out_char    = head_item.ch;
    assign m_last_result = head_item.last;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for calendar_content_line_tokenizer: a directed run of
// the tricky content-line cases, then random lines and noise under three
// ready/valid idling mixes, every token checked against a built-in predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import cclt_pkg::*;

    localparam int PHASE_ITEMS    = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;

    // ------------------------------------------------------------------------
    // Token scoreboard: predicts the tokens of each accepted byte and checks
    // the tokens leaving the block against them in order.
    // ------------------------------------------------------------------------
    class token_scoreboard;
        out_item_t expected_tokens[$];
        out_item_t step_tokens[$];
        mode_t     mode;
        bit        value_seen;
        bit        pname_seen;
        bit        pvalue_seen;
        int        failures;
        int        tokens_seen;

        function new();
            clear_scan();
            failures    = 0;
            tokens_seen = 0;
        endfunction

        function void clear_scan();
            mode        = MODE_LINE;
            value_seen  = 1'b0;
            pname_seen  = 1'b0;
            pvalue_seen = 1'b0;
        endfunction

        // A byte yields two tokens at most; anything beyond is lost.
        function void add_token(kind_t kind, logic [CHAR_W-1:0] ch);
            out_item_t t;
            if (step_tokens.size() >= 2) begin
                return;
            end
            t.kind = kind;
            t.ch   = ch;
            t.last = 1'b0;
            step_tokens.push_back(t);
        endfunction

        function logic [CHAR_W-1:0] upcase(logic [CHAR_W-1:0] c);
            return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
        endfunction

        function void begin_line(logic [CHAR_W-1:0] c);
            if (c == CH_CR) begin
                mode = MODE_LINE_CR;
            end else if (c == CH_LF) begin
                mode = MODE_LINE;
            end else if (c == CH_COLON || c == CH_SEMI) begin
                mode = MODE_SKIP;
            end else begin
                add_token(KIND_NAME_CHAR, upcase(c));
                mode = MODE_NAME;
            end
        endfunction

        function void drop_line(logic [CHAR_W-1:0] c);
            add_token(KIND_PROP_DROP, CH_NUL);
            if (c == CH_CR) begin
                mode = MODE_LINE_CR;
            end else if (c == CH_LF) begin
                mode = MODE_LINE;
            end else begin
                mode = MODE_SKIP;
            end
        endfunction

        function void open_param();
            mode        = MODE_PNAME;
            pname_seen  = 1'b0;
            pvalue_seen = 1'b0;
        endfunction

        function void close_param();
            add_token(pvalue_seen ? KIND_PARAM_KEPT : KIND_PARAM_DISC, CH_NUL);
        endfunction

        function void start_value();
            mode       = MODE_VALUE;
            value_seen = 1'b0;
        endfunction

        function void close_property();
            add_token(value_seen ? KIND_PROP_ENDED : KIND_PROP_DROP, CH_NUL);
        endfunction

        function void value_char(logic [CHAR_W-1:0] c);
            if (c == CH_CR) begin
                mode = MODE_VAL_CR;
            end else if (c == CH_LF) begin
                mode = MODE_VAL_NL;
            end else begin
                add_token(KIND_VALUE_CHAR, c);
                value_seen = 1'b1;
                mode       = MODE_VALUE;
            end
        endfunction

        function void fold_space();
            add_token(KIND_VALUE_CHAR, CH_SP);
            value_seen = 1'b1;
            mode       = MODE_FOLD;
        endfunction

        function void pvalue_char(logic [CHAR_W-1:0] c);
            if (c == CH_SEMI) begin
                close_param();
                open_param();
            end else if (c == CH_COLON) begin
                close_param();
                start_value();
            end else if (c == CH_CR || c == CH_LF) begin
                drop_line(c);
            end else begin
                add_token(KIND_PVALUE_CHAR, c);
                pvalue_seen = 1'b1;
                mode        = MODE_PV;
            end
        endfunction

        // Note an accepted input item and queue the tokens it must cause.
        function void note_byte(logic [CHAR_W-1:0] c, logic eot);
            bit blank;
            bit eol;
            step_tokens.delete();
            blank = (c == CH_SP) || (c == CH_TAB);
            eol   = (c == CH_CR) || (c == CH_LF);
            if (eot || c == CH_NUL) begin
                case (mode)
                    MODE_NAME, MODE_PNAME, MODE_PV_START, MODE_PV, MODE_PV_Q,
                    MODE_PQ_END: begin
                        add_token(KIND_PROP_DROP, CH_NUL);
                    end
                    MODE_VALUE, MODE_VAL_CR, MODE_VAL_NL, MODE_FOLD: begin
                        close_property();
                    end
                    default: begin
                    end
                endcase
                clear_scan();
            end else begin
                case (mode)
                    MODE_LINE_CR: begin
                        if (c == CH_LF) begin
                            mode = MODE_LINE;
                        end else begin
                            begin_line(c);
                        end
                    end
                    MODE_SKIP: begin
                        if (c == CH_CR) begin
                            mode = MODE_LINE_CR;
                        end else if (c == CH_LF) begin
                            mode = MODE_LINE;
                        end
                    end
                    MODE_NAME: begin
                        if (c == CH_COLON) begin
                            start_value();
                        end else if (c == CH_SEMI) begin
                            open_param();
                        end else if (eol) begin
                            drop_line(c);
                        end else begin
                            add_token(KIND_NAME_CHAR, upcase(c));
                        end
                    end
                    MODE_PNAME: begin
                        if (c == CH_EQ) begin
                            if (pname_seen) begin
                                mode = MODE_PV_START;
                            end else begin
                                drop_line(c);
                            end
                        end else if (c == CH_COLON) begin
                            close_param();
                            start_value();
                        end else if (eol) begin
                            drop_line(c);
                        end else begin
                            add_token(KIND_PNAME_CHAR, upcase(c));
                            pname_seen = 1'b1;
                        end
                    end
                    MODE_PV_START: begin
                        if (c == CH_QUOTE) begin
                            mode = MODE_PV_Q;
                        end else begin
                            pvalue_char(c);
                        end
                    end
                    MODE_PV: begin
                        pvalue_char(c);
                    end
                    MODE_PV_Q: begin
                        if (c == CH_QUOTE) begin
                            close_param();
                            mode = MODE_PQ_END;
                        end else if (eol) begin
                            drop_line(c);
                        end else begin
                            add_token(KIND_PVALUE_CHAR, c);
                            pvalue_seen = 1'b1;
                        end
                    end
                    MODE_PQ_END: begin
                        if (c == CH_SEMI) begin
                            open_param();
                        end else if (c == CH_COLON) begin
                            start_value();
                        end else begin
                            drop_line(c);
                        end
                    end
                    MODE_VALUE: begin
                        value_char(c);
                    end
                    MODE_VAL_CR, MODE_VAL_NL: begin
                        if (mode == MODE_VAL_CR && c == CH_LF) begin
                            mode = MODE_VAL_NL;
                        end else if (blank) begin
                            fold_space();
                        end else begin
                            close_property();
                            begin_line(c);
                        end
                    end
                    MODE_FOLD: begin
                        if (!blank) begin
                            value_char(c);
                        end
                    end
                    default: begin
                        begin_line(c);
                    end
                endcase
            end
            if (step_tokens.size() > 0) begin
                step_tokens[step_tokens.size() - 1].last = 1'b1;
            end
            foreach (step_tokens[i]) begin
                expected_tokens.push_back(step_tokens[i]);
            end
        endfunction

        function void flag_mismatch(string msg);
            if (failures < 10) begin
                $display("%s", msg);
            end
            failures++;
        endfunction

        // Check one token leaving the block against the oldest expectation.
        function void check_token(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                  logic last);
            out_item_t want;
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
                flag_mismatch($sformatf("token %0d: kind %0d char %h last %b, none expected",
                                        tokens_seen, kind, ch, last));
                return;
            end
            want = expected_tokens.pop_front();
            if (kind !== want.kind || ch !== want.ch || last !== want.last) begin
                flag_mismatch($sformatf(
                    "token %0d: expected kind %0d char %h last %b, got kind %0d char %h last %b",
                    tokens_seen, want.kind, want.ch, want.last, kind, ch, last));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CHAR_W-1:0]   s_text_byte;
    logic                s_end_of_text;
    logic                m_valid;
    logic                m_ready;
    logic [KIND_W-1:0]   m_token_kind;
    logic [CHAR_W-1:0]   m_out_char;
    logic                m_last_result;

    token_scoreboard tracker;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              items_sent;
    int              quiet_cycles;

    calendar_content_line_tokenizer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_out_char    (m_out_char),
        .m_last_result (m_last_result)
    );

    initial aclk = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: drop ready at random, per the current idling mix.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: sample both handshakes at the rising edge. Note the input item
    // first, so a token of the same edge always finds its expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_byte(s_text_byte, s_end_of_text);
            end
            if (m_valid && m_ready) begin
                tracker.check_token(m_token_kind, m_out_char, m_last_result);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one item at the falling edge, after a random idle gap, and hold it
    // until accepted. Valid is only lowered inside a gap, so no step sees two
    // assignments to it.
    task automatic send_item(input logic [CHAR_W-1:0] b, input logic eot);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_text <= eot;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    // Hold the sender off until every expected token has come out.
    task automatic drain_tokens();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.expected_tokens.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Mostly letters of both cases, some digits and dashes, now and then any
    // printable or high byte (which may well be a delimiter).
    function automatic logic [CHAR_W-1:0] name_char();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return CHAR_W'(8'h41 + $urandom_range(25)
                                          + ($urandom_range(1) ? 8'h20 : 8'h00));
            5:             return CHAR_W'(8'h30 + $urandom_range(9));
            6:             return 8'h2D;
            default:       return CHAR_W'($urandom_range(255, 33));
        endcase
    endfunction

    // Any byte that neither ends the text nor the line.
    function automatic logic [CHAR_W-1:0] value_byte();
        logic [CHAR_W-1:0] c;
        do begin
            c = CHAR_W'($urandom_range(255, 1));
        end while (c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] blank_char();
        return $urandom_range(1) ? CH_SP : CH_TAB;
    endfunction

    task automatic send_line_end();
        case ($urandom_range(2))
            0: send_item(CH_CR, 1'b0);
            1: send_item(CH_LF, 1'b0);
            default: begin
                send_item(CH_CR, 1'b0);
                send_item(CH_LF, 1'b0);
            end
        endcase
    endtask

    // A content line with random name, params and value; folds and line
    // ends vary, and now and then the text ends in place of the line end.
    task automatic send_content_line();
        repeat ($urandom_range(6, 1)) send_item(name_char(), 1'b0);
        repeat ($urandom_range(3, 0)) begin
            send_item(CH_SEMI, 1'b0);
            repeat ($urandom_range(4, 0)) send_item(name_char(), 1'b0);
            if ($urandom_range(4) != 0) begin
                send_item(CH_EQ, 1'b0);
                if ($urandom_range(2) == 0) begin
                    send_item(CH_QUOTE, 1'b0);
                    repeat ($urandom_range(4, 0)) send_item(value_byte(), 1'b0);
                    send_item(CH_QUOTE, 1'b0);
                end else begin
                    repeat ($urandom_range(4, 0)) send_item(name_char(), 1'b0);
                end
            end
        end
        send_item(CH_COLON, 1'b0);
        repeat ($urandom_range(8, 0)) begin
            if ($urandom_range(9) == 0) begin
                send_line_end();
                repeat ($urandom_range(3, 1)) send_item(blank_char(), 1'b0);
            end else begin
                send_item(value_byte(), 1'b0);
            end
        end
        case ($urandom_range(19))
            0:       send_item(CHAR_W'($urandom_range(255)), 1'b1);
            1:       send_item(CH_NUL, 1'b0);
            default: send_line_end();
        endcase
    endtask

    // Noise: raw bytes, delimiters and end-of-text marks in any order.
    task automatic send_noise();
        repeat ($urandom_range(10, 1)) begin
            case ($urandom_range(7))
                0: send_item(CHAR_W'($urandom_range(255)), 1'b1);
                1, 2: begin
                    case ($urandom_range(7))
                        0: send_item(CH_CR, 1'b0);
                        1: send_item(CH_LF, 1'b0);
                        2: send_item(CH_COLON, 1'b0);
                        3: send_item(CH_SEMI, 1'b0);
                        4: send_item(CH_EQ, 1'b0);
                        5: send_item(CH_QUOTE, 1'b0);
                        default: send_item(blank_char(), 1'b0);
                    endcase
                end
                default: send_item(CHAR_W'($urandom_range(255)), 1'b0);
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        tracker       = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_text_byte   = '0;
        s_end_of_text = 1'b0;
        m_ready       = 1'b0;
        items_sent    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 38;
        recv_idle_pct = 75;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty line, then a line with an empty name (skipped silently).
        send_item(CH_LF, 1'b0);
        send_item(CH_SEMI, 1'b0);
        send_item(CH_CR, 1'b0);
        // Top byte as name char, semicolon inside a param name, quoted
        // value, then a stray char after the closing quote drops the line.
        send_item(8'hFF, 1'b0);
        send_item(CH_SEMI, 1'b0);
        send_item(CH_SEMI, 1'b0);
        send_item(CH_EQ, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item("q", 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item("z", 1'b0);
        send_item(CH_LF, 1'b0);
        // Empty param name before '=' drops the line.
        send_item("a", 1'b0);
        send_item(CH_SEMI, 1'b0);
        send_item(CH_EQ, 1'b0);
        send_item(CH_LF, 1'b0);
        // Param without '=' is discarded; the empty value ends in a drop,
        // and the next name char comes on the same byte as that drop.
        send_item("k", 1'b0);
        send_item(CH_SEMI, 1'b0);
        send_item("b", 1'b0);
        send_item(CH_COLON, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item("q", 1'b0);
        // Value that is only a fold, closed by the end-of-text flag.
        send_item(CH_COLON, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_TAB, 1'b0);
        send_item(8'hA5, 1'b1);

        // Three idling mixes; drain between them so the sender pauses.
        for (int phase = 1; phase <= 3; phase++) begin
            while (items_sent < PHASE_ITEMS * phase) begin
                if ($urandom_range(3) == 0) begin
                    send_noise();
                end else begin
                    send_content_line();
                end
            end
            drain_tokens();
            if (phase == 1) begin
                send_idle_pct = 75;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end

        // Let any stray token show up before the verdict.
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (tracker.expected_tokens.size() != 0) begin
            $display("%0d expected tokens never arrived", tracker.expected_tokens.size());
        end
        if (tracker.failures == 0 && tracker.expected_tokens.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[calendar_content_line_tokenizer.f]
hdl/cclt_pkg.sv
hdl/cclt_step.sv
hdl/cclt_outq.sv
hdl/calendar_content_line_tokenizer.sv
tb/testbench.sv
